>>> design/raw_capture_text_parser_assert.svh
// Assertion macros for the raw capture text parser.
// Each macro checks on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef RAW_CAPTURE_TEXT_PARSER_ASSERT_SVH
`define RAW_CAPTURE_TEXT_PARSER_ASSERT_SVH

// The condition holds at every edge outside reset.
`define RCTP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rctp: invariant violated");

// The consequent holds in the cycle after the antecedent.
`define RCTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rctp: sequence check failed");

`endif

>>> design/rctp_pkg.sv
// Shared types, constants and character tables for the raw capture text parser.
// No dependencies; used by raw_capture_text_parser.
`default_nettype none

package rctp_pkg;

    localparam int          CAPTURE_DEPTH_DEF      = 4096;
    localparam int          HEADER_LINE_LENGTH_DEF = 128;
    localparam logic [31:0] FREQ_DEFAULT_RESET     = 32'd433920000;

    // Prefix lengths of the header tags
    localparam int RAW_TAG_LEN  = 9;
    localparam int FREQ_TAG_LEN = 10;

    // Input kind codes
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    // Result kind codes
    localparam logic RES_SAMPLE  = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    // Register index codes
    localparam logic REG_DEFAULT_FREQ = 1'b0;

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        FP_SKIP   = 2'd0,
        FP_DIGITS = 2'd1,
        FP_DONE   = 2'd2
    } t_freq_phase;

    // Raw sample line tag: nine characters, ending in a colon
    function automatic logic [7:0] raw_tag_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h52;
            4'd1:    ch = 8'h41;
            4'd2:    ch = 8'h57;
            4'd3:    ch = 8'h5F;
            4'd4:    ch = 8'h44;
            4'd5:    ch = 8'h61;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h61;
            4'd8:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "Frequency:"
    function automatic logic [7:0] freq_tag_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h46;
            4'd1:    ch = 8'h72;
            4'd2:    ch = 8'h65;
            4'd3:    ch = 8'h71;
            4'd4:    ch = 8'h75;
            4'd5:    ch = 8'h65;
            4'd6:    ch = 8'h6E;
            4'd7:    ch = 8'h63;
            4'd8:    ch = 8'h79;
            4'd9:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // acc * 10 + digit, wrapping at 32 bits
    function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [3:0] dig);
        return (acc << 3) + (acc << 1) + {28'd0, dig};
    endfunction

endpackage

`default_nettype wire

>>> design/raw_capture_text_parser.sv
// Top level of the raw capture text parser: byte parser, result queue and APB register.
// Depends on rctp_pkg and raw_capture_text_parser_assert.svh.
`default_nettype none

// Takes one request per clock on the slave stream: a text byte (tuser = 0) or an end-of-file
// marker (tuser = 1). Header lines are tracked for the "Frequency:" prefix and the raw sample
// tag; in raw mode blank-separated signed decimal numbers come out as sample results, and the
// end marker produces a summary (frequency, sample count, ok) and restarts the parse. Every
// byte is parsed in the cycle it is accepted, with state held in registers, so the block takes
// one request per cycle as long as the master side drains one result per cycle. A result is
// queued on acceptance and shows on the master side behind earlier ones; results wait in a
// four-entry queue, and s_axis_tready is high while it holds two results or fewer, since an
// end marker that flushes a pending number yields two results. Register 0 at byte address 0
// is the default frequency; a new value shows in the summary after the next end marker.

module raw_capture_text_parser #(
    parameter int CAPTURE_DEPTH      = rctp_pkg::CAPTURE_DEPTH_DEF,
    parameter int HEADER_LINE_LENGTH = rctp_pkg::HEADER_LINE_LENGTH_DEF,
    localparam int CNT_W  = $clog2(CAPTURE_DEPTH + 1),
    localparam int DATA_W = ((65 + CNT_W) + 7) / 8 * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // slave stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // byte_value
    input  wire logic              s_axis_tuser,   // kind
    // master stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,   // sample_value, frequency_hz, sample_count,
                                                   // parse_ok, zero pad
    output logic                   m_axis_tuser,   // result_kind
    output logic                   m_axis_tlast,   // last
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int POS_W   = $clog2(HEADER_LINE_LENGTH);
    localparam int ENTRY_W = 1 + 32 + CNT_W + 1 + 1;
    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX      = POS_W'(HEADER_LINE_LENGTH - 1);
    localparam logic [POS_W-1:0] POS_RAW_LAST = POS_W'(rctp_pkg::RAW_TAG_LEN - 1);
    localparam logic [POS_W-1:0] POS_RAW_LEN  = POS_W'(rctp_pkg::RAW_TAG_LEN);
    localparam logic [POS_W-1:0] POS_FREQ_LEN = POS_W'(rctp_pkg::FREQ_TAG_LEN);
    localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(CAPTURE_DEPTH);

    // ---------------------------------------------------------------- registers
    logic [31:0]             r_default_freq;
    logic                    r_raw_mode,   n_raw_mode;
    logic [POS_W-1:0]        r_line_pos,   n_line_pos;
    logic                    r_raw_match,  n_raw_match;
    logic                    r_freq_match, n_freq_match;
    rctp_pkg::t_freq_phase   r_freq_phase, n_freq_phase;
    logic                    r_freq_neg,   n_freq_neg;
    logic [31:0]             r_freq_acc,   n_freq_acc;
    logic [31:0]             r_commit_freq, n_commit_freq;
    logic [31:0]             r_num_acc,    n_num_acc;
    logic                    r_num_neg,    n_num_neg;
    logic                    r_have_digit, n_have_digit;
    logic [CNT_W-1:0]        r_emit_cnt,   n_emit_cnt;

    logic [ENTRY_W-1:0]      r_queue [Q_DEPTH];
    logic [Q_IDX_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]      r_q_cnt;

    // ---------------------------------------------------------------- decode
    logic       in_acc, out_acc, cfg_wr, in_eof;
    logic [7:0] ch;
    logic       is_eol, is_digit, cap_full;
    logic [31:0] sample_val;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_eof   = in_acc && (s_axis_tuser == rctp_pkg::KIND_EOF);
    assign ch       = s_axis_tdata;
    assign is_eol   = (ch == rctp_pkg::CH_LF) || (ch == rctp_pkg::CH_CR);
    assign is_digit = (ch >= rctp_pkg::CH_ZERO) && (ch <= rctp_pkg::CH_NINE);
    assign cap_full = (r_emit_cnt == CNT_FULL);
    assign sample_val = r_num_neg ? (32'd0 - r_num_acc) : r_num_acc;

    // ---------------------------------------------------------------- next state
    logic flush_eof;
    logic emit_text;

    always_comb begin
        n_raw_mode    = r_raw_mode;
        n_line_pos    = r_line_pos;
        n_raw_match   = r_raw_match;
        n_freq_match  = r_freq_match;
        n_freq_phase  = r_freq_phase;
        n_freq_neg    = r_freq_neg;
        n_freq_acc    = r_freq_acc;
        n_commit_freq = r_commit_freq;
        n_num_acc     = r_num_acc;
        n_num_neg     = r_num_neg;
        n_have_digit  = r_have_digit;
        n_emit_cnt    = r_emit_cnt;
        flush_eof     = 1'b0;
        emit_text     = 1'b0;

        if (in_acc && (s_axis_tuser == rctp_pkg::KIND_EOF)) begin
            flush_eof     = r_raw_mode && r_have_digit && !cap_full;
            n_raw_mode    = 1'b0;
            n_line_pos    = '0;
            n_raw_match   = 1'b1;
            n_freq_match  = 1'b1;
            n_freq_phase  = rctp_pkg::FP_SKIP;
            n_freq_neg    = 1'b0;
            n_freq_acc    = '0;
            n_num_acc     = '0;
            n_num_neg     = 1'b0;
            n_have_digit  = 1'b0;
            n_commit_freq = r_default_freq;
            n_emit_cnt    = '0;
        end else if (in_acc && !cap_full && !r_raw_mode) begin
            if (is_eol) begin
                if (r_freq_match && (r_line_pos >= POS_FREQ_LEN)) begin
                    n_commit_freq = r_freq_neg ? (32'd0 - r_freq_acc) : r_freq_acc;
                end
                n_line_pos   = '0;
                n_raw_match  = 1'b1;
                n_freq_match = 1'b1;
                n_freq_phase = rctp_pkg::FP_SKIP;
                n_freq_neg   = 1'b0;
                n_freq_acc   = '0;
            end else if (r_line_pos < POS_MAX) begin
                if ((r_line_pos < POS_RAW_LEN)
                    && (ch != rctp_pkg::raw_tag_char(r_line_pos[3:0]))) begin
                    n_raw_match = 1'b0;
                end
                if (r_line_pos < POS_FREQ_LEN) begin
                    if (ch != rctp_pkg::freq_tag_char(r_line_pos[3:0])) begin
                        n_freq_match = 1'b0;
                    end
                end else begin
                    case (r_freq_phase)
                        rctp_pkg::FP_SKIP: begin
                            if ((ch == rctp_pkg::CH_SPACE) || (ch == rctp_pkg::CH_TAB)
                                || (ch == rctp_pkg::CH_VT) || (ch == rctp_pkg::CH_FF)) begin
                                n_freq_phase = rctp_pkg::FP_SKIP;
                            end else if ((ch == rctp_pkg::CH_PLUS)
                                         || (ch == rctp_pkg::CH_MINUS)) begin
                                n_freq_neg   = (ch == rctp_pkg::CH_MINUS);
                                n_freq_phase = rctp_pkg::FP_DIGITS;
                            end else if (is_digit) begin
                                n_freq_acc   = {28'd0, ch[3:0]};
                                n_freq_phase = rctp_pkg::FP_DIGITS;
                            end else begin
                                n_freq_phase = rctp_pkg::FP_DONE;
                            end
                        end
                        rctp_pkg::FP_DIGITS: begin
                            if (is_digit) begin
                                n_freq_acc = rctp_pkg::mul10_add(r_freq_acc, ch[3:0]);
                            end else begin
                                n_freq_phase = rctp_pkg::FP_DONE;
                            end
                        end
                        default: n_freq_phase = r_freq_phase;
                    endcase
                end
                n_line_pos = r_line_pos + 1'b1;
                // switch to raw mode once the whole raw tag has matched
                if ((r_line_pos == POS_RAW_LAST) && n_raw_match) begin
                    n_raw_mode   = 1'b1;
                    n_num_acc    = '0;
                    n_num_neg    = 1'b0;
                    n_have_digit = 1'b0;
                    n_line_pos   = '0;
                    n_raw_match  = 1'b1;
                    n_freq_match = 1'b1;
                    n_freq_phase = rctp_pkg::FP_SKIP;
                    n_freq_neg   = 1'b0;
                    n_freq_acc   = '0;
                end
            end
        end else if (in_acc && !cap_full) begin
            if (is_eol) begin
                emit_text    = r_have_digit;
                n_num_acc    = '0;
                n_num_neg    = 1'b0;
                n_have_digit = 1'b0;
                n_raw_mode   = 1'b0;
                n_line_pos   = '0;
                n_raw_match  = 1'b1;
                n_freq_match = 1'b1;
                n_freq_phase = rctp_pkg::FP_SKIP;
                n_freq_neg   = 1'b0;
                n_freq_acc   = '0;
            end else if (ch == rctp_pkg::CH_MINUS) begin
                if (!r_have_digit) begin
                    n_num_neg = 1'b1;
                end
            end else if (is_digit) begin
                n_num_acc    = rctp_pkg::mul10_add(r_num_acc, ch[3:0]);
                n_have_digit = 1'b1;
            end else if ((ch == rctp_pkg::CH_SPACE) || (ch == rctp_pkg::CH_TAB)) begin
                if (r_have_digit) begin
                    emit_text    = 1'b1;
                    n_num_acc    = '0;
                    n_num_neg    = 1'b0;
                    n_have_digit = 1'b0;
                end
            end
            if (emit_text) begin
                n_emit_cnt = r_emit_cnt + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- results
    // entry layout: {last, ok, count, value, kind}
    logic [ENTRY_W-1:0] res0, res1;
    logic [1:0]         n_push;
    logic [CNT_W-1:0]   sum_cnt;
    logic [ENTRY_W-1:0] sample_entry, summary_entry;

    always_comb begin
        sum_cnt       = r_emit_cnt + CNT_W'(flush_eof);
        sample_entry  = {1'b0, 1'b0, {CNT_W{1'b0}}, sample_val, rctp_pkg::RES_SAMPLE};
        summary_entry = {1'b1, (sum_cnt != '0), sum_cnt, r_commit_freq, rctp_pkg::RES_SUMMARY};
        res0   = sample_entry;
        res1   = summary_entry;
        n_push = 2'd0;
        if (in_acc && (s_axis_tuser == rctp_pkg::KIND_EOF)) begin
            if (flush_eof) begin
                n_push = 2'd2;
            end else begin
                res0   = summary_entry;
                n_push = 2'd1;
            end
        end else if (emit_text) begin
            res0[ENTRY_W-1] = 1'b1;
            n_push          = 2'd1;
        end
    end

    // ---------------------------------------------------------------- queue
    logic [ENTRY_W-1:0] head;

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (n_push == 2'd2) begin
            r_queue[r_wr_ptr + 1'b1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_IDX_W'(n_push);
            r_rd_ptr <= r_rd_ptr + Q_IDX_W'(out_acc);
            r_q_cnt  <= r_q_cnt + Q_CNT_W'(n_push) - Q_CNT_W'(out_acc);
        end
    end

    assign head          = r_queue[r_rd_ptr];
    assign s_axis_tready = (r_q_cnt <= Q_CNT_W'(2));
    assign m_axis_tvalid = (r_q_cnt != '0);
    assign m_axis_tuser  = head[0];
    assign m_axis_tlast  = head[ENTRY_W-1];

    always_comb begin
        m_axis_tdata = '0;
        if (head[0] == rctp_pkg::RES_SAMPLE) begin
            m_axis_tdata[31:0] = head[32:1];
        end else begin
            m_axis_tdata[63:32]          = head[32:1];
            m_axis_tdata[64 +: CNT_W]    = head[33 +: CNT_W];
            m_axis_tdata[64 + CNT_W]     = head[33 + CNT_W];
        end
    end

    // ---------------------------------------------------------------- parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode    <= 1'b0;
            r_line_pos    <= '0;
            r_raw_match   <= 1'b1;
            r_freq_match  <= 1'b1;
            r_freq_phase  <= rctp_pkg::FP_SKIP;
            r_freq_neg    <= 1'b0;
            r_freq_acc    <= '0;
            r_commit_freq <= rctp_pkg::FREQ_DEFAULT_RESET;
            r_num_acc     <= '0;
            r_num_neg     <= 1'b0;
            r_have_digit  <= 1'b0;
            r_emit_cnt    <= '0;
        end else begin
            r_raw_mode    <= n_raw_mode;
            r_line_pos    <= n_line_pos;
            r_raw_match   <= n_raw_match;
            r_freq_match  <= n_freq_match;
            r_freq_phase  <= n_freq_phase;
            r_freq_neg    <= n_freq_neg;
            r_freq_acc    <= n_freq_acc;
            r_commit_freq <= n_commit_freq;
            r_num_acc     <= n_num_acc;
            r_num_neg     <= n_num_neg;
            r_have_digit  <= n_have_digit;
            r_emit_cnt    <= n_emit_cnt;
        end
    end

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_freq <= rctp_pkg::FREQ_DEFAULT_RESET;
        end else if (cfg_wr && (paddr[2] == rctp_pkg::REG_DEFAULT_FREQ)) begin
            r_default_freq <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rctp_pkg::REG_DEFAULT_FREQ) ? r_default_freq : 32'd0;

    // ---------------------------------------------------------------- checks
`include "raw_capture_text_parser_assert.svh"

    `RCTP_ASSERT_ALWAYS(a_queue_bound, r_q_cnt <= Q_CNT_W'(Q_DEPTH))
    `RCTP_ASSERT_ALWAYS(a_count_bound, r_emit_cnt <= CNT_FULL)
    `RCTP_ASSERT_ALWAYS(a_line_bound, r_line_pos <= POS_MAX)
    `RCTP_ASSERT_NEXT(a_eof_restart, in_eof, !r_raw_mode && (r_emit_cnt == '0))

endmodule

`default_nettype wire
